/* design/sync_word_length_prefixed_deframer_defines.svh */
// ---------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion helpers, clocked on i_clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef SYNC_WORD_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_LENGTH_PREFIXED_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define SWLPD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("deframer assertion failed");

// next-cycle implication
`define SWLPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("deframer assertion failed");

`endif

/* design/swlpd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swlpd_pkg
// Shared types and constants of the length-prefixed deframer.
// ---------------------------------------------------------------------------
package swlpd_pkg;

    localparam int LENGTH_DIGITS_DEF = 14;
    localparam int LENGTH_BITS_DEF   = 32;
    localparam int SYNC_LEN          = 5;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       empty_frame;
    } t_result;

    // "ITEST"
    function automatic logic [7:0] sync_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h49;
            3'd1:    b = 8'h54;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'h53;
            3'd4:    b = 8'h54;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* design/sync_word_length_prefixed_deframer.sv */
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register, decoded by the parser and registered as its result beat.
// Throughput: one byte per cycle; the input register and the result register each
// take a new beat while the next stage drains, so back-pressure only stalls when both are full.
// Reset: synchronous, active low; both registers empty, parser back to sync hunt.
// ---------------------------------------------------------------------------
// sync_word_length_prefixed_deframer
// Hunts for sync word ITEST, reads a decimal length, forwards the payload.
// ---------------------------------------------------------------------------
`include "sync_word_length_prefixed_deframer_defines.svh"

module sync_word_length_prefixed_deframer
    import swlpd_pkg::*;
#(
    parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
    output logic       m_axis_tlast,   // frame_end
    output logic [0:0] m_axis_tuser    // [0] empty_frame
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic       r_out_empty;

    logic       out_free;
    logic       proc;
    t_result    res;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    swlpd_parser #(
        .LENGTH_DIGITS(LENGTH_DIGITS),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc),
        .i_byte  (r_in_byte),
        .o_result(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && res.valid) begin
            r_out_byte  <= res.payload_byte;
            r_out_last  <= res.frame_end;
            r_out_empty <= res.empty_frame;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_byte;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_empty;

    `SWLPD_ASSERT_IMPL(a_empty_is_marker, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast && m_axis_tdata == 8'h00)
    `SWLPD_ASSERT_IMPL(a_result_needs_beat, res.valid, proc)
    `SWLPD_ASSERT_IMPL(a_stall_only_when_full, !s_axis_tready, r_in_valid && r_out_valid && !m_axis_tready)
    `SWLPD_ASSERT_NEXT(a_result_lands, proc && res.valid, m_axis_tvalid)

endmodule

/* design/swlpd_parser.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swlpd_parser
// Frame state machine: sync hunt, separator, length digits, payload.
// ---------------------------------------------------------------------------
module swlpd_parser
    import swlpd_pkg::*;
#(
    parameter int LENGTH_DIGITS = LENGTH_DIGITS_DEF,
    parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    localparam int CW = $clog2(LENGTH_DIGITS + 1);
    localparam int AW = LENGTH_BITS + 1;
    localparam int PW = LENGTH_BITS + 5;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_SEP     = 2'd1;
    localparam logic [1:0] PH_DIGITS  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [2:0] SYNC_LAST  = 3'(SYNC_LEN - 1);

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_sync, n_sync;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [AW-1:0]          r_accum, n_accum;
    logic                   r_invalid, n_invalid;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;

    logic [7:0]             digit_off;
    logic [PW-1:0]          acc_ext;
    logic [PW-1:0]          prod;
    logic [LENGTH_BITS-1:0] rem_dec;
    t_result                res;

    always_comb begin
        n_phase   = r_phase;
        n_sync    = r_sync;
        n_cnt     = r_cnt;
        n_accum   = r_accum;
        n_invalid = r_invalid;
        n_rem     = r_rem;
        res       = '0;
        digit_off = 8'(i_byte - ASCII_ZERO);
        acc_ext   = PW'(r_accum);
        prod      = (acc_ext << 3) + (acc_ext << 1) + PW'(digit_off[3:0]);
        rem_dec   = r_rem - LENGTH_BITS'(r_rem != '0);

        case (r_phase)
            PH_HUNT: begin
                if (i_byte == sync_byte(r_sync)) begin
                    if (r_sync == SYNC_LAST) begin
                        n_sync  = '0;
                        n_phase = PH_SEP;
                    end else begin
                        n_sync = r_sync + 3'd1;
                    end
                end else begin
                    n_sync = (i_byte == sync_byte(3'd0)) ? 3'd1 : 3'd0;
                end
            end
            PH_SEP: begin
                n_phase   = PH_DIGITS;
                n_cnt     = '0;
                n_accum   = '0;
                n_invalid = 1'b0;
            end
            PH_DIGITS: begin
                if (!(i_byte inside {[8'h30:8'h39]})) begin
                    n_invalid = 1'b1;
                end else if (!r_invalid) begin
                    if (|prod[PW-1:LENGTH_BITS]) begin
                        n_invalid = 1'b1;
                        n_accum   = {1'b1, {LENGTH_BITS{1'b0}}};
                    end else begin
                        n_accum = prod[AW-1:0];
                    end
                end
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(LENGTH_DIGITS - 1)) begin
                    n_cnt = '0;
                    if (n_invalid || n_accum == '0) begin
                        n_phase          = PH_HUNT;
                        res.valid        = 1'b1;
                        res.frame_end    = 1'b1;
                        res.empty_frame  = 1'b1;
                    end else begin
                        n_rem   = n_accum[LENGTH_BITS-1:0];
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                res.valid        = 1'b1;
                res.payload_byte = i_byte;
                n_rem            = rem_dec;
                if (rem_dec == '0) begin
                    res.frame_end = 1'b1;
                    n_phase       = PH_HUNT;
                    n_sync        = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_sync    <= '0;
            r_cnt     <= '0;
            r_accum   <= '0;
            r_invalid <= 1'b0;
            r_rem     <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_sync    <= n_sync;
            r_cnt     <= n_cnt;
            r_accum   <= n_accum;
            r_invalid <= n_invalid;
            r_rem     <= n_rem;
        end
    end

    assign o_result = i_fire ? res : '0;

endmodule

/* tb/sync_word_length_prefixed_deframer_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sync_word_length_prefixed_deframer_tb
// Self-checking bench for the ITEST length-prefixed deframer. Directed frames
// cover sync restarts, empty, bad-digit and overflowing length fields and
// payload edge bytes. Random frames, noise and broken sync words follow under
// random idling on both streams, with one long output hold-off. A predictor
// in the scoreboard tracks the parser and matches every output beat in order.
// ---------------------------------------------------------------------------
module sync_word_length_prefixed_deframer_tb;
    import swlpd_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          TARGET_BYTES   = 1850;
    localparam logic [39:0] SYNC_WORD      = "ITEST";
    localparam logic [7:0]  ASCII_ZERO     = 8'h30;
    localparam logic [7:0]  ASCII_NINE     = 8'h39;
    localparam logic [63:0] LEN_MAX        = (64'd1 << LENGTH_BITS_DEF) - 64'd1;

    typedef enum logic [1:0] {HUNT, SEPARATOR, LENGTH_FIELD, PAYLOAD} t_parse_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
        logic       empty_frame;
    } t_out_beat;

    typedef logic [7:0] t_octet_q[$];

    function automatic logic [7:0] sync_char(input int unsigned k);
        return SYNC_WORD[8 * (SYNC_LEN - 1 - k) +: 8];
    endfunction

    class deframer_scoreboard;
        t_parse_phase phase;
        int unsigned  sync_hits;
        int unsigned  digits_seen;
        logic [63:0]  len_value;
        logic         len_bad;
        logic [63:0]  bytes_left;
        t_out_beat    payload_beats_due[$];
        int           errors;

        function new();
            phase       = HUNT;
            sync_hits   = 0;
            digits_seen = 0;
            len_value   = '0;
            len_bad     = 1'b0;
            bytes_left  = '0;
            errors      = 0;
        endfunction

        function void take_rx_byte(input logic [7:0] b);
            t_out_beat   beat;
            logic [63:0] len;
            case (phase)
                HUNT: begin
                    if (sync_hits < SYNC_LEN && b == sync_char(sync_hits))
                        sync_hits++;
                    else
                        sync_hits = (b == sync_char(0)) ? 1 : 0;
                    if (sync_hits >= SYNC_LEN) begin
                        sync_hits = 0;
                        phase     = SEPARATOR;
                    end
                end
                SEPARATOR: begin
                    phase       = LENGTH_FIELD;
                    digits_seen = 0;
                    len_value   = '0;
                    len_bad     = 1'b0;
                end
                LENGTH_FIELD: begin
                    if (b < ASCII_ZERO || b > ASCII_NINE) begin
                        len_bad = 1'b1;
                    end else if (!len_bad) begin
                        len_value = len_value * 10 + 64'(b - ASCII_ZERO);
                        if (len_value > LEN_MAX) begin
                            len_bad   = 1'b1;
                            len_value = LEN_MAX + 1;
                        end
                    end
                    digits_seen++;
                    if (digits_seen >= LENGTH_DIGITS_DEF) begin
                        digits_seen = 0;
                        len = len_bad ? 64'd0 : len_value;
                        if (len == 0) begin
                            phase             = HUNT;
                            beat.payload_byte = 8'h00;
                            beat.frame_end    = 1'b1;
                            beat.empty_frame  = 1'b1;
                            payload_beats_due.push_back(beat);
                        end else begin
                            bytes_left = len;
                            phase      = PAYLOAD;
                        end
                    end
                end
                default: begin
                    if (bytes_left > 0)
                        bytes_left--;
                    beat.payload_byte = b;
                    beat.empty_frame  = 1'b0;
                    beat.frame_end    = (bytes_left == 0);
                    if (bytes_left == 0) begin
                        phase     = HUNT;
                        sync_hits = 0;
                    end
                    payload_beats_due.push_back(beat);
                end
            endcase
        endfunction

        function void match_output_beat(input logic [7:0] data, input logic last,
                                        input logic empty);
            t_out_beat want;
            if (payload_beats_due.size() == 0) begin
                $error("unexpected beat: payload_byte 0x%02h frame_end %0b empty_frame %0b",
                       data, last, empty);
                errors++;
                return;
            end
            want = payload_beats_due.pop_front();
            if (data !== want.payload_byte) begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", want.payload_byte, data);
                errors++;
            end
            if (last !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, last);
                errors++;
            end
            if (empty !== want.empty_frame) begin
                $error("empty_frame: expected %0b, got %0b", want.empty_frame, empty);
                errors++;
            end
        endfunction

        function int pending();
            return payload_beats_due.size();
        endfunction
    endclass

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = 8'h00;  // [7:0] rx_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] payload_byte
    logic       m_axis_tlast;            // frame_end
    logic [0:0] m_axis_tuser;            // [0] empty_frame

    deframer_scoreboard sb;
    logic steady  = 1'b0;
    logic hold_rx = 1'b0;
    int   sent_bytes  = 0;
    int   idle_cycles = 0;

    sync_word_length_prefixed_deframer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.match_output_beat(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
    end

    // watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        logic hold_taken;
        hold_taken = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx && !hold_taken) begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 27);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (!steady) begin
            while ($urandom_range(99) < 27) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.take_rx_byte(b);
        sent_bytes++;
    endtask

    function automatic t_octet_q length_text(input longint unsigned v);
        t_octet_q t;
        for (int i = 0; i < LENGTH_DIGITS_DEF; i++) begin
            t.push_front(ASCII_ZERO + 8'(v % 10));
            v = v / 10;
        end
        return t;
    endfunction

    function automatic logic [7:0] non_digit();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v >= ASCII_ZERO && v <= ASCII_NINE);
        return v;
    endfunction

    function automatic t_octet_q random_bytes(input int n);
        t_octet_q q;
        repeat (n) q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    task automatic send_frame(input logic [7:0] sep, input t_octet_q len_field,
                              input t_octet_q payload);
        t_octet_q q;
        for (int k = 0; k < SYNC_LEN; k++)
            q.push_back(sync_char(k));
        q.push_back(sep);
        foreach (len_field[i]) q.push_back(len_field[i]);
        foreach (payload[i]) q.push_back(payload[i]);
        foreach (q[i]) send_byte(q[i]);
    endtask

    task automatic send_random_frame();
        int       kind;
        int       n;
        int       at;
        t_octet_q lf;
        t_octet_q pl;
        kind = $urandom_range(99);
        n    = 0;
        if (kind < 12) begin
            lf = length_text(0);
        end else if (kind < 20) begin
            lf = length_text($urandom_range(12));
            lf[$urandom_range(LENGTH_DIGITS_DEF - 1)] = non_digit();
        end else if (kind < 26) begin
            for (int i = 0; i < LENGTH_DIGITS_DEF; i++)
                lf.push_back(ASCII_ZERO + 8'($urandom_range(9)));
            lf[0] = ASCII_ZERO + 8'($urandom_range(1, 9));
        end else begin
            n  = (kind < 30) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            lf = length_text(n);
        end
        pl = random_bytes(n);
        if (n >= SYNC_LEN && $urandom_range(9) == 0) begin
            at = $urandom_range(n - SYNC_LEN);
            for (int k = 0; k < SYNC_LEN; k++)
                pl[at + k] = sync_char(k);
        end
        send_frame(8'($urandom_range(255)), lf, pl);
    endtask

    initial begin
        t_octet_q lf;
        t_octet_q pl;
        int       r;
        logic     hold_done;
        sb = new();
        hold_done = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // partial sync broken by 'I', then a zero-length frame
        send_byte("I");
        send_byte("T");
        send_byte("E");
        send_byte("S");
        send_byte("I");
        send_byte("T");
        send_byte("E");
        send_byte("S");
        send_byte("T");
        send_byte(8'h00);
        lf = length_text(0);
        foreach (lf[i]) send_byte(lf[i]);

        // payload edge bytes
        pl = {8'h00, 8'hFF};
        send_frame(8'hFF, length_text(2), pl);
        pl = {8'hAA};
        send_frame(8'h20, length_text(1), pl);
        // sync word inside payload must pass through
        pl = {8'h49, 8'h54, 8'h45, 8'h53, 8'h54, 8'h49};
        send_frame(8'h55, length_text(6), pl);

        // bad digits just outside the digit range
        pl = {};
        lf = length_text(3);
        lf[LENGTH_DIGITS_DEF - 1] = ASCII_ZERO - 1;
        send_frame(8'h01, lf, pl);
        lf = length_text(3);
        lf[0] = ASCII_NINE + 1;
        send_frame(8'h80, lf, pl);

        // length overflow, just past the limit and far past it
        send_frame(8'h7F, length_text(64'd4294967296), pl);
        send_frame(8'hFE, length_text(64'd99999999999999), pl);

        while (sent_bytes < TARGET_BYTES) begin
            if (!hold_done && sent_bytes > 300) begin
                hold_done = 1'b1;
                hold_rx   = 1'b1;
                send_frame(8'($urandom_range(255)), length_text(40), random_bytes(40));
            end
            steady = (sent_bytes >= 700 && sent_bytes < 1000);
            r = $urandom_range(99);
            if (r < 8) begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(1))
                        send_byte(sync_char($urandom_range(SYNC_LEN - 1)));
                    else
                        send_byte(8'($urandom_range(255)));
                end
            end else if (r < 14) begin
                r = $urandom_range(1, SYNC_LEN - 1);
                for (int k = 0; k < r; k++)
                    send_byte(sync_char(k));
                send_byte(8'($urandom_range(255)));
            end else begin
                send_random_frame();
            end
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sync_word_length_prefixed_deframer.f */
+incdir+design
design/swlpd_pkg.sv
design/swlpd_parser.sv
design/sync_word_length_prefixed_deframer.sv
tb/sync_word_length_prefixed_deframer_tb.sv
